[rtl/mpsd_pkg.sv]
// shared types, codes and microprogram of the maze path search unit
package mpsd_pkg;

	localparam int COORD_W = 3;
	localparam int STEP_W  = 4;
	localparam int NDIRS   = 4;

	localparam int DIR_UP    = 0;
	localparam int DIR_LEFT  = 1;
	localparam int DIR_DOWN  = 2;
	localparam int DIR_RIGHT = 3;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic REG_GOAL_ROW = 1'b0;
	localparam logic REG_GOAL_COL = 1'b1;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [STEP_W-1:0]  step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_INIT,
		OP_CLOSE,
		OP_SEED,
		OP_FLOOD,
		OP_PICK,
		OP_EMIT_STACK,
		OP_EMIT_GOAL,
		OP_RESTORE,
		OP_EMIT_MISS
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_SEARCH,
		COND_FLOOD_MORE,
		COND_NO_CAND,
		COND_NOT_GOAL,
		COND_STACK_DONE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic changed;
		logic [NDIRS-1:0] cand;
		logic any_open;
	} grid_stat_t;

	typedef struct packed {
		logic search_acc;
		logic flood_more;
		logic no_cand;
		logic not_goal;
		logic stack_done;
		logic out_busy;
	} seq_stat_t;

	localparam step_t S_IDLE    = 4'd0;
	localparam step_t S_INIT    = 4'd1;
	localparam step_t S_CLOSE   = 4'd2;
	localparam step_t S_SEED    = 4'd3;
	localparam step_t S_FLOOD   = 4'd4;
	localparam step_t S_PICK    = 4'd5;
	localparam step_t S_ATGOAL  = 4'd6;
	localparam step_t S_RD      = 4'd7;
	localparam step_t S_WR      = 4'd8;
	localparam step_t S_LOOP    = 4'd9;
	localparam step_t S_GOAL    = 4'd10;
	localparam step_t S_DONE    = 4'd11;
	localparam step_t S_MISS    = 4'd12;
	localparam step_t S_MISSOUT = 4'd13;
	localparam step_t S_END     = 4'd14;

	function automatic uword_t ucode(step_t step);
		uword_t w;
		unique case (step)
			S_IDLE:    w = '{op: OP_ACCEPT,     cond: COND_NO_SEARCH,  target: S_IDLE};
			S_INIT:    w = '{op: OP_INIT,       cond: COND_NEVER,      target: S_IDLE};
			S_CLOSE:   w = '{op: OP_CLOSE,      cond: COND_NEVER,      target: S_IDLE};
			S_SEED:    w = '{op: OP_SEED,       cond: COND_NEVER,      target: S_IDLE};
			S_FLOOD:   w = '{op: OP_FLOOD,      cond: COND_FLOOD_MORE, target: S_FLOOD};
			S_PICK:    w = '{op: OP_PICK,       cond: COND_NO_CAND,    target: S_MISS};
			S_ATGOAL:  w = '{op: OP_NOP,        cond: COND_NOT_GOAL,   target: S_CLOSE};
			S_RD:      w = '{op: OP_NOP,        cond: COND_STACK_DONE, target: S_GOAL};
			S_WR:      w = '{op: OP_EMIT_STACK, cond: COND_OUT_BUSY,   target: S_WR};
			S_LOOP:    w = '{op: OP_NOP,        cond: COND_ALWAYS,     target: S_RD};
			S_GOAL:    w = '{op: OP_EMIT_GOAL,  cond: COND_OUT_BUSY,   target: S_GOAL};
			S_DONE:    w = '{op: OP_NOP,        cond: COND_ALWAYS,     target: S_IDLE};
			S_MISS:    w = '{op: OP_RESTORE,    cond: COND_NEVER,      target: S_IDLE};
			S_MISSOUT: w = '{op: OP_EMIT_MISS,  cond: COND_OUT_BUSY,   target: S_MISSOUT};
			S_END:     w = '{op: OP_NOP,        cond: COND_ALWAYS,     target: S_IDLE};
			default:   w = '{op: OP_NOP,        cond: COND_ALWAYS,     target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

[rtl/mpsd_ifs.sv]
// item and result channel interfaces of the maze path search unit
interface mpsd_item_if;
	logic valid;
	logic ready;
	logic command;
	mpsd_pkg::coord_t cell_row;
	mpsd_pkg::coord_t cell_col;
	logic cell_open;

	modport source (output valid, command, cell_row, cell_col, cell_open, input ready);
	modport sink (input valid, command, cell_row, cell_col, cell_open, output ready);
endinterface

interface mpsd_result_if;
	logic valid;
	logic ready;
	logic found;
	mpsd_pkg::coord_t path_row;
	mpsd_pkg::coord_t path_col;
	logic last;

	modport source (output valid, found, path_row, path_col, last, input ready);
	modport sink (input valid, found, path_row, path_col, last, output ready);
endinterface

[rtl/mpsd_seq.sv]
// microprogram sequencer: step counter, control word rom, conditional jumps
module mpsd_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mpsd_pkg::seq_stat_t   stat,
	output mpsd_pkg::op_t         op
);

	mpsd_pkg::step_t  upc_q;
	mpsd_pkg::step_t  upc_d;
	mpsd_pkg::uword_t word;
	logic             take;

	assign word = mpsd_pkg::ucode(upc_q);

	always_comb begin
		unique case (word.cond)
			mpsd_pkg::COND_NEVER:      take = 1'b0;
			mpsd_pkg::COND_ALWAYS:     take = 1'b1;
			mpsd_pkg::COND_NO_SEARCH:  take = !stat.search_acc;
			mpsd_pkg::COND_FLOOD_MORE: take = stat.flood_more;
			mpsd_pkg::COND_NO_CAND:    take = stat.no_cand;
			mpsd_pkg::COND_NOT_GOAL:   take = stat.not_goal;
			mpsd_pkg::COND_STACK_DONE: take = stat.stack_done;
			mpsd_pkg::COND_OUT_BUSY:   take = stat.out_busy;
			default:                   take = 1'b0;
		endcase
		upc_d = take ? word.target : upc_q + 1'b1;
	end

	always_comb begin
		op = word.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= mpsd_pkg::S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

[rtl/mpsd_grid.sv]
// grid cells with flood-fill reachability from the goal and neighbor tests
module mpsd_grid #(
	parameter int ROWS = 4,
	parameter int COLS = 8
) (
	input  logic                  clk,
	input  mpsd_pkg::op_t         op,
	input  logic                  ld_en,
	input  mpsd_pkg::coord_t      ld_row,
	input  mpsd_pkg::coord_t      ld_col,
	input  logic                  ld_open,
	input  mpsd_pkg::coord_t      cur_row,
	input  mpsd_pkg::coord_t      cur_col,
	input  mpsd_pkg::coord_t      goal_row,
	input  mpsd_pkg::coord_t      goal_col,
	output mpsd_pkg::grid_stat_t  stat
);

	localparam int NCELLS = ROWS * COLS;

	logic [NCELLS-1:0] grid_q;
	logic [NCELLS-1:0] reach_q;
	logic              saved_q;
	logic [NCELLS-1:0] reach_nx;
	logic [NCELLS-1:0] cur_oh, goal_oh, ld_oh;
	logic [NCELLS-1:0] up_r, dn_r, lf_r, rt_r;
	logic [NCELLS-1:0] is_up, is_left, is_down, is_right;

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		localparam int R = i / COLS;
		localparam int C = i % COLS;
		localparam mpsd_pkg::coord_t RV = mpsd_pkg::coord_t'(R);
		localparam mpsd_pkg::coord_t CV = mpsd_pkg::coord_t'(C);

		assign cur_oh[i]  = (cur_row == RV) && (cur_col == CV);
		assign goal_oh[i] = (goal_row == RV) && (goal_col == CV);
		assign ld_oh[i]   = (ld_row == RV) && (ld_col == CV);

		if (R > 0) begin : g_n
			assign up_r[i]    = reach_q[i-COLS];
			assign is_down[i] = cur_oh[i-COLS];
		end else begin : g_no_n
			assign up_r[i]    = 1'b0;
			assign is_down[i] = 1'b0;
		end
		if (R < ROWS - 1) begin : g_s
			assign dn_r[i]  = reach_q[i+COLS];
			assign is_up[i] = cur_oh[i+COLS];
		end else begin : g_no_s
			assign dn_r[i]  = 1'b0;
			assign is_up[i] = 1'b0;
		end
		if (C > 0) begin : g_w
			assign lf_r[i]     = reach_q[i-1];
			assign is_right[i] = cur_oh[i-1];
		end else begin : g_no_w
			assign lf_r[i]     = 1'b0;
			assign is_right[i] = 1'b0;
		end
		if (C < COLS - 1) begin : g_e
			assign rt_r[i]    = reach_q[i+1];
			assign is_left[i] = cur_oh[i+1];
		end else begin : g_no_e
			assign rt_r[i]    = 1'b0;
			assign is_left[i] = 1'b0;
		end
	end

	assign reach_nx = reach_q | (grid_q & (up_r | dn_r | lf_r | rt_r));

	always_comb begin
		stat.changed                   = reach_nx != reach_q;
		stat.cand[mpsd_pkg::DIR_UP]    = |(is_up & grid_q & reach_q);
		stat.cand[mpsd_pkg::DIR_LEFT]  = |(is_left & grid_q & reach_q);
		stat.cand[mpsd_pkg::DIR_DOWN]  = |(is_down & grid_q & reach_q);
		stat.cand[mpsd_pkg::DIR_RIGHT] = |(is_right & grid_q & reach_q);
		stat.any_open = |((is_up | is_left | is_down | is_right) & grid_q);
	end

	always_ff @(posedge clk) begin
		case (op)
			mpsd_pkg::OP_ACCEPT: begin
				if (ld_en) begin
					grid_q <= (grid_q & ~ld_oh) | (ld_oh & {NCELLS{ld_open}});
				end
			end
			mpsd_pkg::OP_CLOSE: begin
				saved_q <= |(grid_q & cur_oh);
				grid_q  <= grid_q & ~cur_oh;
			end
			mpsd_pkg::OP_SEED: begin
				reach_q <= goal_oh & grid_q;
			end
			mpsd_pkg::OP_FLOOD: begin
				reach_q <= reach_nx;
			end
			mpsd_pkg::OP_RESTORE: begin
				// dead end at the start: origin keeps its value only if it had no open neighbor
				if (!stat.any_open && saved_q) begin
					grid_q <= grid_q | cur_oh;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/mpsd_stack.sv]
// path stack memory, one write port and one registered read port
module mpsd_stack #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/maze_path_search_dfs_unit.sv]
// top level of the maze path search unit: walk registers, output stage, register port
//
// channel   role    beat
// items     sink    command, cell_row, cell_col, cell_open
// results   source  found, path_row, path_col, last
// apb       slave   goal_row at 0x0, goal_col at 0x4
//
// a load beat is taken in the idle step; items.ready stays high between searches
// a search runs an init step, then per path step close, seed, flood passes (at most
// ROWS*COLS), pick and goal check, then read, emit and loop steps per path beat and
// emit and done steps for the goal beat, or restore, emit and end steps for a miss
// stalls on results hold the sequencer in its emit step; the output register
// lets the next item be taken while the final beat still waits
// reset clears the sequencer, walk position and counters, goal registers and output valid only
module maze_path_search_dfs_unit #(
	parameter int ROWS = 4,
	parameter int COLS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	mpsd_item_if.sink           items,
	mpsd_result_if.source       results,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int NCELLS = ROWS * COLS;
	localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam int DW     = 2 * mpsd_pkg::COORD_W;

	mpsd_pkg::op_t        op;
	mpsd_pkg::grid_stat_t gstat;
	mpsd_pkg::seq_stat_t  sstat;

	mpsd_pkg::coord_t goal_row_q, goal_col_q;
	mpsd_pkg::coord_t cur_row_q, cur_col_q;
	logic [AW-1:0]    count_q, idx_q;
	logic             out_valid_q;
	logic             found_q, last_q;
	mpsd_pkg::coord_t prow_q, pcol_q;

	logic                   acc, ld_en, push, move, out_busy, load_out, cfg_wr;
	logic [mpsd_pkg::NDIRS-1:0] dir_oh;
	logic [DW-1:0]          rdata;

	assign acc      = items.valid && items.ready;
	assign ld_en    = acc && (items.command == mpsd_pkg::CMD_LOAD);
	assign move     = |gstat.cand;
	assign push     = (op == mpsd_pkg::OP_PICK) && move;
	assign out_busy = out_valid_q && !results.ready;
	assign load_out = (op inside {mpsd_pkg::OP_EMIT_STACK, mpsd_pkg::OP_EMIT_GOAL,
		mpsd_pkg::OP_EMIT_MISS}) && !out_busy;

	assign items.ready = (op == mpsd_pkg::OP_ACCEPT);

	always_comb begin
		sstat.search_acc = acc && (items.command == mpsd_pkg::CMD_SEARCH);
		sstat.flood_more = gstat.changed;
		sstat.no_cand    = !move;
		sstat.not_goal   = !((cur_row_q == goal_row_q) && (cur_col_q == goal_col_q));
		sstat.stack_done = (idx_q == count_q);
		sstat.out_busy   = out_busy;
	end

	// up, left, down, right priority
	always_comb begin
		dir_oh = '0;
		if (gstat.cand[mpsd_pkg::DIR_UP]) begin
			dir_oh[mpsd_pkg::DIR_UP] = 1'b1;
		end else if (gstat.cand[mpsd_pkg::DIR_LEFT]) begin
			dir_oh[mpsd_pkg::DIR_LEFT] = 1'b1;
		end else if (gstat.cand[mpsd_pkg::DIR_DOWN]) begin
			dir_oh[mpsd_pkg::DIR_DOWN] = 1'b1;
		end else if (gstat.cand[mpsd_pkg::DIR_RIGHT]) begin
			dir_oh[mpsd_pkg::DIR_RIGHT] = 1'b1;
		end
	end

	mpsd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (sstat),
		.op     (op)
	);

	mpsd_grid #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_grid (
		.clk      (clk),
		.op       (op),
		.ld_en    (ld_en),
		.ld_row   (items.cell_row),
		.ld_col   (items.cell_col),
		.ld_open  (items.cell_open),
		.cur_row  (cur_row_q),
		.cur_col  (cur_col_q),
		.goal_row (goal_row_q),
		.goal_col (goal_col_q),
		.stat     (gstat)
	);

	mpsd_stack #(
		.DEPTH (NCELLS),
		.AW    (AW),
		.DW    (DW)
	) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (count_q),
		.wdata ({cur_row_q, cur_col_q}),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			count_q   <= '0;
			idx_q     <= '0;
		end else begin
			case (op)
				mpsd_pkg::OP_INIT: begin
					cur_row_q <= '0;
					cur_col_q <= '0;
					count_q   <= '0;
					idx_q     <= '0;
				end
				mpsd_pkg::OP_PICK: begin
					if (move) begin
						count_q <= count_q + AW'(1);
						if (dir_oh[mpsd_pkg::DIR_UP]) begin
							cur_row_q <= cur_row_q - 3'd1;
						end else if (dir_oh[mpsd_pkg::DIR_LEFT]) begin
							cur_col_q <= cur_col_q - 3'd1;
						end else if (dir_oh[mpsd_pkg::DIR_DOWN]) begin
							cur_row_q <= cur_row_q + 3'd1;
						end else if (dir_oh[mpsd_pkg::DIR_RIGHT]) begin
							cur_col_q <= cur_col_q + 3'd1;
						end
					end
				end
				mpsd_pkg::OP_EMIT_STACK: begin
					if (!out_busy) begin
						idx_q <= idx_q + AW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			case (op)
				mpsd_pkg::OP_EMIT_STACK: begin
					found_q <= 1'b1;
					prow_q  <= rdata[DW-1:mpsd_pkg::COORD_W];
					pcol_q  <= rdata[mpsd_pkg::COORD_W-1:0];
					last_q  <= 1'b0;
				end
				mpsd_pkg::OP_EMIT_GOAL: begin
					found_q <= 1'b1;
					prow_q  <= goal_row_q;
					pcol_q  <= goal_col_q;
					last_q  <= 1'b1;
				end
				default: begin
					found_q <= 1'b0;
					prow_q  <= '0;
					pcol_q  <= '0;
					last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign results.valid    = out_valid_q;
	assign results.found    = found_q;
	assign results.path_row = prow_q;
	assign results.path_col = pcol_q;
	assign results.last     = last_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_row_q <= '0;
			goal_col_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == mpsd_pkg::REG_GOAL_ROW) begin
				goal_row_q <= pwdata[mpsd_pkg::COORD_W-1:0];
			end else begin
				goal_col_q <= pwdata[mpsd_pkg::COORD_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == mpsd_pkg::REG_GOAL_COL) begin
			prdata = {{(32-mpsd_pkg::COORD_W){1'b0}}, goal_col_q};
		end else begin
			prdata = {{(32-mpsd_pkg::COORD_W){1'b0}}, goal_row_q};
		end
	end

	a_idx_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= count_q)
		else $error("emit index ran past stack depth");

	a_goal_after_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(op == mpsd_pkg::OP_EMIT_GOAL) |-> (idx_q == count_q))
		else $error("goal beat before all stack beats");

	a_stack_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(op == mpsd_pkg::OP_EMIT_STACK && !out_busy) |=>
		(results.valid && results.found && !results.last))
		else $error("stack beat not presented");

	a_miss_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(op == mpsd_pkg::OP_EMIT_MISS && !out_busy) |=>
		(results.valid && !results.found && results.last))
		else $error("not-found beat not presented");

endmodule
